### hw/rtl/point_matrix_transform_top_defines.svh
// Assertion macros for the point matrix transform block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POINT_MATRIX_TRANSFORM_TOP_DEFINES_SVH
`define POINT_MATRIX_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmt check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define PMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmt check failed: next-cycle implication");

`endif

### hw/rtl/pmt_pkg.sv
// Shared types and constants for the point matrix transform block.
// No dependencies.
`timescale 1ns / 1ps

package pmt_pkg;

    localparam int STORE_DIM = 4;                  // coefficient store is STORE_DIM x STORE_DIM
    localparam int MAT_ROWS  = 4;                  // rows that produce nonzero outputs
    localparam int VEC_LEN   = 4;                  // components entering each dot product
    localparam int STORE_N   = STORE_DIM * STORE_DIM;
    localparam int INDEX_W   = $clog2(STORE_N);

    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int PAIR_W    = PROD_W + 1;
    localparam int SUM_W     = PROD_W + $clog2(STORE_DIM);
    localparam int FRAC_BITS = 16;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_POINT = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic        [INDEX_W-1:0] t_index;

endpackage

### hw/rtl/point_matrix_transform_top.sv
// Top level of the point matrix transform: 4x4 Q15.16 matrix times 4-vector.
// Depends on pmt_pkg and point_matrix_transform_top_defines.svh.
`timescale 1ns / 1ps
`include "point_matrix_transform_top_defines.svh"

// Usage
//   Input channel (i_valid / o_stall): one transaction per cycle while o_stall is low. i_func selects
//   a coefficient load (FUNC_LOAD: i_coef_value goes to entry i_coef_index,
//   row*4+column, no result) or a point (FUNC_POINT: i_comp_u..i_comp_w).
//   Output channel (o_valid / i_stall): one result transaction per point,
//   o_out_x..o_out_h, each a row of the matrix dotted with the point, rounded
//   toward zero from Q33.32 to Q15.16 and saturated to 32 bits.
//   Pipeline: a point passes four register stages: products, pair sums,
//   row sums, round/saturate.
//   Throughput: one transaction per cycle while the receiver does not stall, set by the 16
//   parallel 32x32 multipliers in the first stage and the fully pipelined adder tree.
//   Loads take effect at their accepting edge, so a point right behind a load
//   already sees the new coefficient; later loads never disturb points in flight
//   because products are formed at acceptance.
//   Stall: each stage advances when its successor is empty or moving, so bubbles
//   are squeezed out; o_stall rises only when all four stages hold data and the
//   receiver stalls. A stalled result holds steady.
//   Reset (synchronous, active low): clears all valid bits and zeroes the
//   coefficient store.
module point_matrix_transform_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_func,
    input  pmt_pkg::t_index        i_coef_index,
    input  pmt_pkg::t_word         i_coef_value,
    input  pmt_pkg::t_word         i_comp_u,
    input  pmt_pkg::t_word         i_comp_v,
    input  pmt_pkg::t_word         i_comp_d,
    input  pmt_pkg::t_word         i_comp_w,
    output logic                   o_valid,
    input  logic                   i_stall,
    output pmt_pkg::t_word         o_out_x,
    output pmt_pkg::t_word         o_out_y,
    output pmt_pkg::t_word         o_out_z,
    output pmt_pkg::t_word         o_out_h
);
    import pmt_pkg::*;

    localparam int HALF = STORE_DIM / 2;

    // Round toward zero (bias negatives before the arithmetic shift), then
    // clamp to the signed 32-bit range.
    function automatic t_word round_sat(input t_sum s);
        t_sum q;
        t_sum bias;
        bias = s[SUM_W-1] ? t_sum'((1 << FRAC_BITS) - 1) : '0;
        q    = (s + bias) >>> FRAC_BITS;
        if (q[SUM_W-1:WORD_W-1] == '0 || q[SUM_W-1:WORD_W-1] == '1) begin
            round_sat = q[WORD_W-1:0];
        end else if (q[SUM_W-1]) begin
            round_sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            round_sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

    // Coefficient store: small, every entry read at a fixed product slot.
    t_word r_coef [STORE_N];

    t_word w_pt [STORE_DIM];

    // Pipeline valid bits.
    logic  r_vld1, r_vld2, r_vld3, r_vld_out;
    logic  w_adv1, w_adv2, w_adv3, w_adv_out;
    logic  w_in_acc, w_load, w_point;

    // Stage payloads.
    t_prod r_prod [STORE_DIM][STORE_DIM];
    t_prod n_prod [STORE_DIM][STORE_DIM];
    t_pair r_pair [STORE_DIM][HALF];
    t_pair n_pair [STORE_DIM][HALF];
    t_sum  r_sum  [STORE_DIM];
    t_sum  n_sum  [STORE_DIM];
    t_word r_out  [STORE_DIM];
    t_word n_out  [STORE_DIM];

    assign w_pt[0] = i_comp_u;
    assign w_pt[1] = i_comp_v;
    assign w_pt[2] = i_comp_d;
    assign w_pt[3] = i_comp_w;

    // Backpressure chain: a stage moves when empty or when its successor moves.
    assign w_adv_out = !r_vld_out || !i_stall;
    assign w_adv3    = !r_vld3 || w_adv_out;
    assign w_adv2    = !r_vld2 || w_adv3;
    assign w_adv1    = !r_vld1 || w_adv2;
    assign o_stall   = !w_adv1;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_load    = w_in_acc && (i_func == FUNC_LOAD);
    assign w_point   = w_in_acc && (i_func == FUNC_POINT);

    // Stage 1: one 32x32 product per matrix entry; unused columns are zero.
    always_comb begin
        for (int r = 0; r < STORE_DIM; r++) begin
            for (int c = 0; c < STORE_DIM; c++) begin
                if (c < VEC_LEN) begin
                    n_prod[r][c] = t_prod'(r_coef[INDEX_W'(r * STORE_DIM + c)])
                                   * t_prod'(w_pt[c]);
                end else begin
                    n_prod[r][c] = '0;
                end
            end
        end
    end

    // Stage 2: pair sums.
    always_comb begin
        for (int r = 0; r < STORE_DIM; r++) begin
            for (int p = 0; p < HALF; p++) begin
                n_pair[r][p] = t_pair'(r_prod[r][2*p]) + t_pair'(r_prod[r][2*p+1]);
            end
        end
    end

    // Stage 3: row sums.
    always_comb begin
        for (int r = 0; r < STORE_DIM; r++) begin
            n_sum[r] = '0;
            for (int p = 0; p < HALF; p++) begin
                n_sum[r] = n_sum[r] + t_sum'(r_pair[r][p]);
            end
        end
    end

    // Stage 4: round, saturate; rows past MAT_ROWS read zero.
    always_comb begin
        for (int r = 0; r < STORE_DIM; r++) begin
            if (r < MAT_ROWS) begin
                n_out[r] = round_sat(r_sum[r]);
            end else begin
                n_out[r] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_N; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_load) begin
            r_coef[i_coef_index] <= i_coef_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_vld_out <= 1'b0;
        end else begin
            if (w_adv1)    r_vld1    <= w_point;
            if (w_adv2)    r_vld2    <= r_vld1;
            if (w_adv3)    r_vld3    <= r_vld2;
            if (w_adv_out) r_vld_out <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_prod <= n_prod;
        end
        if (w_adv2) begin
            r_pair <= n_pair;
        end
        if (w_adv3) begin
            r_sum <= n_sum;
        end
        if (w_adv_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld_out;
    assign o_out_x = r_out[0];
    assign o_out_y = r_out[1];
    assign o_out_z = r_out[2];
    assign o_out_h = r_out[3];

    // A load lands in the addressed entry.
    `PMT_ASSERT_NEXT(a_load_writes, i_clk, i_rst_n, w_load, r_coef[$past(i_coef_index)] == $past(i_coef_value))
    // A stalled result stays valid and unchanged.
    `PMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_out_h))
    // An accepted point always enters stage 1.
    `PMT_ASSERT_NEXT(a_point_enters, i_clk, i_rst_n, w_point, r_vld1)
    // Input backpressure only when every stage is full and the receiver stalls.
    `PMT_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, o_stall, r_vld1 && r_vld2 && r_vld3 && r_vld_out && i_stall)
    // A row sum ready to move is never dropped on the way to the output.
    `PMT_ASSERT_NEXT(a_no_drop, i_clk, i_rst_n, r_vld3 && w_adv_out, r_vld_out)

endmodule

### bench/tb_point_matrix_transform_top.sv
// Testbench for point_matrix_transform_top: coefficient loads and point transforms
// checked against an in-bench Q15.16 matrix predictor. Depends on pmt_pkg and the RTL.
`timescale 1ns / 1ps

module tb_point_matrix_transform_top;
    import pmt_pkg::*;

    // Four 32-bit lanes: point components u,v,d,w in, or outputs x,y,z,h out.
    typedef logic [3:0][WORD_W-1:0] t_quad;

    localparam t_word Q_ONE      = 32'sh0001_0000;  // 1.0 in Q15.16
    localparam t_word Q_MAX      = 32'sh7FFF_FFFF;
    localparam t_word Q_MIN      = 32'sh8000_0000;
    localparam int    RAND_ITEMS = 1900;
    localparam int    HOLD_AT    = 600;             // inputs taken before the long hold-off
    localparam int    HOLD_LEN   = 80;
    localparam int    DRAIN_CYC  = 12;              // pipeline is four stages deep
    localparam int    IDLE_LIMIT = 2000;            // cycles without any transaction

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the coefficient store, predicts the
    // four outputs for each accepted point and compares them in order.
    // ------------------------------------------------------------------
    class PointTransformChecker;
        t_word coefs[STORE_N];
        t_quad pending_points[$];
        int    errors;

        function new();
            foreach (coefs[i]) coefs[i] = '0;
            errors = 0;
        endfunction

        // Exact dot product, truncated toward zero by FRAC_BITS, saturated.
        function automatic t_word transform_row(int row, t_quad pt);
            logic signed [71:0] acc;
            logic        [71:0] mag;
            logic        [71:0] q;
            logic        [71:0] neg_q;
            t_word              coef;
            t_word              comp;
            acc = '0;
            for (int c = 0; c < STORE_DIM; c++) begin
                if (c < VEC_LEN) begin
                    coef = coefs[row * STORE_DIM + c];
                    comp = pt[c];
                    acc  = acc + 72'(coef) * 72'(comp);
                end
            end
            mag = acc[71] ? 72'(-acc) : 72'(acc);
            q   = mag >> FRAC_BITS;
            if (acc[71]) begin
                if (q > 72'h8000_0000) return Q_MIN;
                neg_q = -q;
                return neg_q[31:0];
            end
            if (q > 72'h7FFF_FFFF) return Q_MAX;
            return q[31:0];
        endfunction

        // Called for every accepted input transaction, in acceptance order.
        function void note_transaction(logic func, t_index idx, t_word val, t_quad pt);
            t_quad res;
            if (func == FUNC_LOAD) begin
                coefs[idx] = val;
            end else begin
                for (int r = 0; r < 4; r++)
                    res[r] = (r < MAT_ROWS && r < STORE_DIM) ? transform_row(r, pt) : '0;
                pending_points.push_back(res);
            end
        endfunction

        function void check_result(t_quad got);
            string names[4] = '{"out_x", "out_y", "out_z", "out_h"};
            t_quad exp_res;
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h h=%h",
                         $time, got[0], got[1], got[2], got[3]);
                errors++;
                return;
            end
            exp_res = pending_points.pop_front();
            for (int f = 0; f < 4; f++) begin
                if (got[f] !== exp_res[f]) begin
                    $display("%0t: %s mismatch, expected %h, actual %h",
                             $time, names[f], exp_res[f], got[f]);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals. Every bench-driven signal starts at a known value.
    // ------------------------------------------------------------------
    logic   i_clk        = 1'b0;
    logic   i_rst_n      = 1'b0;
    logic   i_valid      = 1'b0;
    logic   o_stall;
    logic   i_func       = FUNC_LOAD;
    t_index i_coef_index = '0;
    t_word  i_coef_value = '0;
    t_word  i_comp_u     = '0;
    t_word  i_comp_v     = '0;
    t_word  i_comp_d     = '0;
    t_word  i_comp_w     = '0;
    logic   o_valid;
    logic   i_stall      = 1'b0;
    t_word  o_out_x;
    t_word  o_out_y;
    t_word  o_out_z;
    t_word  o_out_h;

    PointTransformChecker checker_sb = new();
    int inputs_taken = 0;     // accepted input transactions, read by the receiver
    int idle_cycles  = 0;

    point_matrix_transform_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_comp_u     (i_comp_u),
        .i_comp_v     (i_comp_v),
        .i_comp_d     (i_comp_d),
        .i_comp_w     (i_comp_w),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_z      (o_out_z),
        .o_out_h      (o_out_h)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Monitor and watchdog. Runs at the rising edge and reads pre-edge values,
    // since all drivers (bench and DUT) update through nonblocking assignments.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                checker_sb.note_transaction(i_func, i_coef_index, i_coef_value,
                                            {i_comp_w, i_comp_d, i_comp_v, i_comp_u});
                inputs_taken++;
            end
            if (o_valid && !i_stall)
                checker_sb.check_result({o_out_h, o_out_z, o_out_y, o_out_x});
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    bit send_gappy = 1'b0;

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Mix of extremes, full-range words and small values (within +-4.0) so that
    // both saturated and in-range outputs show up.
    function automatic t_word rand_word(bit small_only);
        int sel;
        sel = small_only ? 9 : $urandom_range(0, 9);
        case (sel)
            0: begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return t_word'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // Offer one transaction and hold it until the edge that accepts it.
    task automatic offer(input logic func, input t_index idx, input t_word val,
                         input t_word u, input t_word v, input t_word d, input t_word w);
        i_valid      <= 1'b1;
        i_func       <= func;
        i_coef_index <= idx;
        i_coef_value <= val;
        i_comp_u     <= u;
        i_comp_v     <= v;
        i_comp_d     <= d;
        i_comp_w     <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic idle_for(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic pace();
        if (send_gappy && $urandom_range(0, 1) == 0)
            idle_for(gap_len());
    endtask

    // Load: point fields carry junk that must be ignored.
    task automatic load_coef(input t_index idx, input t_word val);
        offer(FUNC_LOAD, idx, val, $urandom(), $urandom(), $urandom(), $urandom());
        pace();
    endtask

    // Point: coefficient fields carry junk that must be ignored.
    task automatic send_point(input t_word u, input t_word v, input t_word d, input t_word w);
        offer(FUNC_POINT, t_index'($urandom()), $urandom(), u, v, d, w);
        pace();
    endtask

    initial begin
        int items;
        int kind;
        bit small_mat;
        bit small_pt;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A point before any load sees the cleared store.
        send_gappy = 1'b1;
        send_point(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE);
        // Identity matrix, then extremes pass straight through.
        for (int k = 0; k < 4; k++)
            load_coef(t_index'(k * 5), Q_ONE);
        send_point(Q_MAX, Q_MIN, '0, -32'sd1);
        // Fractional product with a negative sign truncates toward zero.
        load_coef(t_index'(0), 32'sd1);
        send_point(-32'sd1, Q_ONE, Q_ONE, Q_ONE);
        // Most negative times most negative overflows high; times max, low.
        load_coef(t_index'(15), Q_MIN);
        send_point('0, '0, '0, Q_MIN);
        send_point('0, '0, '0, Q_MAX);
        load_coef(t_index'(15), Q_MAX);
        send_point(Q_MIN, Q_MIN, Q_MIN, Q_MAX);
        // -1.0 and 0.5 on the diagonal, back to back without gaps.
        send_gappy = 1'b0;
        load_coef(t_index'(5), -Q_ONE);
        send_point('0, 32'sh0003_8000, '0, '0);
        load_coef(t_index'(10), 32'sh0000_8000);
        send_point(Q_ONE, Q_ONE, -32'sd3, Q_ONE);
        // Whole store at the extremes.
        for (int k = 0; k < STORE_N; k++)
            load_coef(t_index'(k), (k % 2) ? Q_MIN : Q_MAX);
        send_point(Q_MAX, Q_MIN, Q_MAX, Q_MIN);

        // Random part: mostly points, single loads now and then, and
        // occasional full matrix reloads so the store moves between
        // small and full-range contents.
        items = 0;
        small_pt = 1'b0;
        while (items < RAND_ITEMS) begin
            if (items % 64 == 0) begin
                send_gappy = ($urandom_range(0, 2) != 0);
                small_pt   = $urandom_range(0, 1);
            end
            kind = $urandom_range(0, 99);
            if (kind == 0) begin
                small_mat = $urandom_range(0, 2) != 0;
                for (int k = 0; k < STORE_N; k++)
                    load_coef(t_index'(k), rand_word(small_mat));
                items += STORE_N;
            end else if (kind < 9) begin
                load_coef(t_index'($urandom_range(0, STORE_N - 1)), rand_word(1'b0));
                items++;
            end else begin
                send_point(rand_word(small_pt), rand_word(small_pt),
                           rand_word(small_pt), rand_word(small_pt));
                items++;
            end
        end
        i_valid <= 1'b0;

        // Drain, then watch a few more cycles for stray results.
        while (checker_sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (checker_sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver side: calm stretches, stretches with short and long stalls,
    // and one long hold-off so the pipeline fills and pushes back.
    // ------------------------------------------------------------------
    initial begin
        bit held;
        int len;

        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && inputs_taken >= HOLD_AT) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(20, 120)) @(posedge i_clk);
            end else begin
                len = $urandom_range(3, 12);
                repeat (len) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge i_clk);
                    i_stall <= 1'b1;
                    repeat (gap_len()) @(posedge i_clk);
                end
            end
        end
    end

endmodule
